// ===== hdl/tha_pkg.sv =====
// package for the temperature health alarm unit
// holds status and motor codes, register indexes and register reset values
// no dependencies
package tha_pkg;

    typedef enum logic [1:0]
    {
        STATUS_NORMAL  = 2'd0,
        STATUS_WARNING = 2'd1,
        STATUS_DANGER  = 2'd2
    } status_t;

    typedef enum logic [1:0]
    {
        MOTOR_OFF       = 2'd0,
        MOTOR_STEADY    = 2'd1,
        MOTOR_HEARTBEAT = 2'd2,
        MOTOR_PATTERN   = 2'd3
    } motor_t;

    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DANGER_LOW  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WARN        = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DANGER_HIGH = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PERSIST     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEARTBEAT   = 3'd4;

    localparam logic [7:0]  RST_DANGER_LOW  = 8'd36;
    localparam logic [7:0]  RST_WARN        = 8'd38;
    localparam logic [7:0]  RST_DANGER_HIGH = 8'd40;
    localparam logic [31:0] RST_PERSIST     = 32'd2000000;
    localparam logic [31:0] RST_HEARTBEAT   = 32'd10000000;

endpackage

// ===== hdl/temperature_health_alarm_unit.sv =====
// temperature health alarm unit: status, led and motor mode per temperature sample
// depends on tha_pkg for status and motor codes, register indexes and reset values
// an accepted request passes the input register, then the result register on the master side
// throughput: one request per cycle while m_tready does not stall the result register, set by
//   the single compare and subtract pass between the input register and the result register
// reset: rst_n asynchronous active low; levels and times return to their defaults,
//   status goes to normal, high flag and both time marks clear, pipeline empties
module temperature_health_alarm_unit
#(
    parameter int TIME_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // temperature [7:0], now_us [39:8]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // health_status [1:0], led_on [2], motor_mode [4:3], zero

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tha_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]                        cfg_data
);

    logic [7:0]  danger_low_reg;
    logic [7:0]  warn_reg;
    logic [7:0]  danger_high_reg;
    logic [31:0] persist_reg;
    logic [31:0] heartbeat_reg;

    logic        in_valid_reg;
    logic [7:0]  in_temp_reg;
    logic [31:0] in_now_reg;

    tha_pkg::status_t       status_reg;
    tha_pkg::status_t       status_next;
    logic                   high_seen_reg;
    logic                   high_seen_next;
    logic [TIME_BITS-1:0]   high_start_reg;
    logic [TIME_BITS-1:0]   high_start_next;
    logic [TIME_BITS-1:0]   last_beat_reg;
    logic [TIME_BITS-1:0]   last_beat_next;
    tha_pkg::motor_t        motor_next;

    logic                   m_valid_reg;
    tha_pkg::status_t       out_status_reg;
    tha_pkg::motor_t        out_motor_reg;

    logic                   out_free;
    logic                   advance;
    logic [TIME_BITS+31:0]  now_ext;
    logic [TIME_BITS-1:0]   now_t;
    logic [TIME_BITS-1:0]   high_elapsed;
    logic [TIME_BITS-1:0]   beat_elapsed;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_motor_reg, (out_status_reg == tha_pkg::STATUS_DANGER),
                       out_status_reg};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            danger_low_reg  <= tha_pkg::RST_DANGER_LOW;
            warn_reg        <= tha_pkg::RST_WARN;
            danger_high_reg <= tha_pkg::RST_DANGER_HIGH;
            persist_reg     <= tha_pkg::RST_PERSIST;
            heartbeat_reg   <= tha_pkg::RST_HEARTBEAT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tha_pkg::REG_DANGER_LOW:  danger_low_reg  <= cfg_data[7:0];
                tha_pkg::REG_WARN:        warn_reg        <= cfg_data[7:0];
                tha_pkg::REG_DANGER_HIGH: danger_high_reg <= cfg_data[7:0];
                tha_pkg::REG_PERSIST:     persist_reg     <= cfg_data;
                tha_pkg::REG_HEARTBEAT:   heartbeat_reg   <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_temp_reg <= s_tdata[7:0];
            in_now_reg  <= s_tdata[39:8];
        end
    end

    // time wraps at TIME_BITS
    assign now_ext = {{TIME_BITS{1'b0}}, in_now_reg};
    assign now_t   = now_ext[TIME_BITS-1:0];

    always_comb
    begin
        status_next     = status_reg;
        high_seen_next  = high_seen_reg;
        high_start_next = high_start_reg;
        last_beat_next  = last_beat_reg;
        motor_next      = tha_pkg::MOTOR_OFF;

        if (in_temp_reg < danger_low_reg || in_temp_reg > danger_high_reg)
        begin
            status_next = tha_pkg::STATUS_DANGER;
        end
        if (in_temp_reg >= danger_low_reg && in_temp_reg <= warn_reg)
        begin
            status_next    = tha_pkg::STATUS_NORMAL;
            high_seen_next = 1'b0;
        end
        if (in_temp_reg > warn_reg && status_next != tha_pkg::STATUS_DANGER)
        begin
            if (!high_seen_next)
            begin
                high_start_next = now_t;
                high_seen_next  = 1'b1;
            end
            if ({32'd0, high_elapsed} > {{TIME_BITS{1'b0}}, persist_reg})
            begin
                status_next = tha_pkg::STATUS_WARNING;
            end
        end

        unique case (status_next)
            tha_pkg::STATUS_NORMAL:
            begin
                if ({32'd0, beat_elapsed} > {{TIME_BITS{1'b0}}, heartbeat_reg})
                begin
                    last_beat_next = now_t;
                    motor_next     = tha_pkg::MOTOR_HEARTBEAT;
                end
            end
            tha_pkg::STATUS_WARNING: motor_next = tha_pkg::MOTOR_STEADY;
            default:                 motor_next = tha_pkg::MOTOR_PATTERN;
        endcase
    end

    // a fresh high start gives zero elapsed time
    assign high_elapsed = (high_seen_reg && !(in_temp_reg >= danger_low_reg
                          && in_temp_reg <= warn_reg)) ? (now_t - high_start_reg)
                          : {TIME_BITS{1'b0}};
    assign beat_elapsed = now_t - last_beat_reg;

    // block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg     <= tha_pkg::STATUS_NORMAL;
            high_seen_reg  <= 1'b0;
            high_start_reg <= {TIME_BITS{1'b0}};
            last_beat_reg  <= {TIME_BITS{1'b0}};
        end
        else if (advance)
        begin
            status_reg     <= status_next;
            high_seen_reg  <= high_seen_next;
            high_start_reg <= high_start_next;
            last_beat_reg  <= last_beat_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= status_next;
            out_motor_reg  <= motor_next;
        end
    end

    a_led_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2] == (out_status_reg == tha_pkg::STATUS_DANGER)))
        else $error("led state does not follow danger status");

    a_pattern_only_in_danger: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((out_motor_reg == tha_pkg::MOTOR_PATTERN)
                      == (out_status_reg == tha_pkg::STATUS_DANGER)))
        else $error("danger pattern and danger status disagree");

    a_warning_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_status_reg == tha_pkg::STATUS_WARNING)
        |-> (out_motor_reg == tha_pkg::MOTOR_STEADY))
        else $error("warning without steady motor");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(status_reg) && $stable(last_beat_reg)))
        else $error("state changed without a request");

endmodule
